[design/fpcs_pkg.sv]
package fpcs_pkg;
    localparam int NUM_STRINGS_DEF = 6;
    localparam int NUM_FRETS_DEF   = 22;
    localparam int MAX_OUT_DEF     = 16;
    localparam int CENTS_W         = 20;
    localparam int DIST_W          = 19;
    localparam int FREQ_W          = 24;
    localparam logic [DIST_W-1:0] TOL_RESET = 19'd800;
    localparam logic [15:0] CENTS_SCALE = 16'd19200;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic [0:0] REG_TOLERANCE = 1'b0;
endpackage

[design/fret_position_candidate_search.sv]
// A load runs the log2 unit: normalize, one squaring per fraction bit, scale, done.
// A query then adds two table scans (minimum, then selection) and a flush;
// a stalled result pauses the scan.
// One item at a time: s_tready is low while the shared log2 unit, the scans or the flush
// run and while a result transfer is pending.
// Reset (aresetn low, synchronous) clears control state and sets tolerance to 800.
// The reference table has no reset and must be loaded before queries.
module fret_position_candidate_search #(
    parameter int NUM_STRINGS = fpcs_pkg::NUM_STRINGS_DEF,
    parameter int NUM_FRETS   = fpcs_pkg::NUM_FRETS_DEF,
    parameter int MAX_OUT     = fpcs_pkg::MAX_OUT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: entry_index[7:0], pitch_freq[31:8]
    input  logic [31:0] s_tdata,
    // tuser: func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: candidate_index[7:0], string_number[10:8], fret_number[15:11],
    // distance[34:16], zero fill
    output logic [39:0] m_tdata,
    // tuser: status
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TBL = NUM_STRINGS * NUM_FRETS;
    localparam int AW  = $clog2(TBL);
    localparam int SW  = $clog2(NUM_STRINGS + 1);
    localparam int FW  = $clog2(NUM_FRETS + 1);
    localparam int OW  = $clog2(MAX_OUT + 1);
    localparam int DW  = fpcs_pkg::DIST_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_MIN   = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic        func_reg;
    logic [7:0]  idx_reg;
    logic [DW-1:0] tol_reg, min_reg, min_next;
    logic [19:0] obs_reg;
    logic [SW-1:0] s_reg, s_next;
    logic [FW-1:0] f_reg, f_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic        rd_v_reg;
    logic [SW-1:0] rs_reg;
    logic [FW-1:0] rf_reg;
    logic [AW-1:0] ra_reg;
    logic        scan_end_reg;
    logic [OW-1:0] cnt_reg, cnt_next;
    logic [DW:0] limit_reg;
    logic        log_start, log_done;
    logic [19:0] log_cents, rdata;
    logic        acc;
    logic        zero_query;
    logic [20:0] diff;
    logic [DW-1:0] ent_dist;
    logic        m_v_reg;
    logic [39:0] m_d_reg;
    logic [1:0]  m_u_reg;
    logic        m_l_reg;
    logic        hold_v_reg;
    logic [39:0] hold_d_reg;
    logic        scan_last;
    logic        stop_reg;
    logic        sel_hit;
    logic        trunc_hit;
    logic        keep_hit;
    logic        flush_emit;
    logic        emit;
    logic        stall;
    logic [AW-1:0] raddr;

    assign acc        = s_tvalid && s_tready;
    assign zero_query = acc && s_tuser == fpcs_pkg::FUNC_QUERY && s_tdata[31:8] == '0;
    assign s_tready   = (state_reg == S_IDLE) && !m_v_reg;
    assign log_start  = acc && !zero_query;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == fpcs_pkg::REG_TOLERANCE) ? {13'd0, tol_reg} : 32'd0;

    // The scan pauses while a result waits for the receiver.
    assign stall = m_v_reg && !m_tready;

    // While paused, re-read the entry under evaluation so its data stays aligned.
    assign raddr = stall ? ra_reg : addr_reg;

    fpcs_log2 u_log (
        .aclk(aclk), .aresetn(aresetn), .start(log_start),
        .freq(s_tdata[31:8]), .done(log_done), .cents(log_cents)
    );

    fpcs_ram #(.WIDTH(fpcs_pkg::CENTS_W), .DEPTH(TBL)) u_ram (
        .aclk(aclk),
        .we(log_done && func_reg == fpcs_pkg::FUNC_LOAD && {24'd0, idx_reg} < TBL),
        .waddr(idx_reg[AW-1:0]), .wdata(log_cents), .raddr(raddr), .rdata(rdata)
    );

    // Absolute distance of the entry read last cycle.
    assign diff = ({1'b0, rdata} > {1'b0, obs_reg}) ? ({1'b0, rdata} - {1'b0, obs_reg})
                                                   : ({1'b0, obs_reg} - {1'b0, rdata});
    assign ent_dist = diff[DW-1:0];
    assign scan_last = ({{(32-SW){1'b0}}, s_reg} == NUM_STRINGS - 1) &&
                       ({{(32-FW){1'b0}}, f_reg} == NUM_FRETS - 1);

    // Selection hits and the result register loads they cause.
    assign sel_hit    = rd_v_reg && state_reg == S_SEL && {1'b0, ent_dist} < limit_reg &&
                        !stop_reg;
    assign trunc_hit  = sel_hit && ({{(32-OW){1'b0}}, cnt_reg} >= MAX_OUT);
    assign keep_hit   = sel_hit && !trunc_hit;
    assign flush_emit = state_reg == S_FLUSH && hold_v_reg && !m_v_reg;
    assign emit       = !stall && (trunc_hit || (keep_hit && hold_v_reg) || flush_emit);

    // Walk string-major, fret ascending; address = string + strings*fret.
    always_comb begin
        state_next = state_reg;
        s_next     = s_reg;
        f_next     = f_reg;
        addr_next  = addr_reg;
        min_next   = min_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    if (zero_query) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV: begin
                if (log_done) begin
                    state_next = (func_reg == fpcs_pkg::FUNC_QUERY) ? S_MIN : S_IDLE;
                    s_next = '0;
                    f_next = '0;
                    addr_next = '0;
                    min_next = '1;
                end
            end
            S_MIN, S_SEL: begin
                if (rd_v_reg && state_reg == S_MIN && ent_dist < min_reg) begin
                    min_next = ent_dist;
                end
                if (keep_hit) begin
                    cnt_next = cnt_reg + OW'(1);
                end
                if (!(rd_v_reg && scan_end_reg)) begin
                    if ({{(32-FW){1'b0}}, f_reg} == NUM_FRETS - 1) begin
                        f_next    = '0;
                        s_next    = s_reg + SW'(1);
                        addr_next = AW'({{(32-SW){1'b0}}, s_reg} + 1);
                    end else begin
                        f_next    = f_reg + FW'(1);
                        addr_next = AW'({{(32-AW){1'b0}}, addr_reg} + NUM_STRINGS);
                    end
                end else if (state_reg == S_MIN) begin
                    state_next = S_SEL;
                    s_next = '0;
                    f_next = '0;
                    addr_next = '0;
                    cnt_next = '0;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!m_v_reg && !hold_v_reg) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output: hold one candidate, emit the previous one when the next hit
    // or the scan end decides its last flag. The pipeline stalls while a result waits for the receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tol_reg    <= fpcs_pkg::TOL_RESET;
            min_reg    <= '0;
            rd_v_reg   <= 1'b0;
            m_v_reg    <= 1'b0;
            hold_v_reg <= 1'b0;
            stop_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == fpcs_pkg::REG_TOLERANCE) begin
                tol_reg <= pwdata[DW-1:0];
            end
            // Result register: a new transfer loads it, an accepted one empties it.
            if (zero_query) begin
                m_v_reg <= 1'b1;
                m_d_reg <= '0;
                m_u_reg <= fpcs_pkg::ST_ZERO;
                m_l_reg <= 1'b1;
            end else if (emit) begin
                m_v_reg <= 1'b1;
                m_d_reg <= hold_d_reg;
                m_u_reg <= trunc_hit ? fpcs_pkg::ST_TRUNC : fpcs_pkg::ST_OK;
                m_l_reg <= trunc_hit || flush_emit;
            end else if (m_tready) begin
                m_v_reg <= 1'b0;
            end
            if (!stall) begin
                state_reg <= state_next;
                s_reg     <= s_next;
                f_reg     <= f_next;
                addr_reg  <= addr_next;
                min_reg   <= min_next;
                cnt_reg   <= cnt_next;
                rd_v_reg  <= (state_reg == S_MIN || state_reg == S_SEL) && state_next == state_reg;
                rs_reg    <= s_reg;
                rf_reg    <= f_reg;
                ra_reg    <= addr_reg;
                scan_end_reg <= scan_last;
                if (state_reg == S_MIN && state_next == S_SEL) begin
                    limit_reg <= {1'b0, min_next} + {1'b0, tol_reg};
                end
                if (state_reg == S_CONV && log_done) begin
                    obs_reg  <= log_cents;
                    stop_reg <= 1'b0;
                end else if (trunc_hit) begin
                    // A further hit: the held one is last and truncated.
                    hold_v_reg <= 1'b0;
                    stop_reg   <= 1'b1;
                end else if (keep_hit) begin
                    hold_v_reg <= 1'b1;
                    hold_d_reg <= {5'd0, ent_dist, 5'(rf_reg), 3'(rs_reg), 8'(ra_reg)};
                end else if (flush_emit) begin
                    hold_v_reg <= 1'b0;
                end
            end
        end
    end

    // Capture the item fields on acceptance.
    always_ff @(posedge aclk) begin
        if (acc) begin
            func_reg <= s_tuser;
            idx_reg  <= s_tdata[7:0];
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_d_reg;
    assign m_tuser  = m_u_reg;
    assign m_tlast  = m_l_reg;
endmodule

[design/fpcs_ram.sv]
module fpcs_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 132
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/fpcs_log2.sv]
module fpcs_log2 (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fpcs_pkg::FREQ_W-1:0] freq,
    output logic                       done,
    output logic [fpcs_pkg::CENTS_W-1:0] cents
);
    localparam logic [2:0] LS_IDLE  = 3'd0;
    localparam logic [2:0] LS_NORM  = 3'd1;
    localparam logic [2:0] LS_SQ    = 3'd2;
    localparam logic [2:0] LS_SCALE = 3'd3;
    localparam logic [2:0] LS_DONE  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  exp_reg, exp_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] y_reg, y_next;
    logic [23:0] frac_reg, frac_next;
    logic [19:0] cents_reg, cents_next;
    logic [63:0] sq;
    logic [33:0] sq_sh;
    logic [44:0] scaled;

    // Shared squaring unit and the final scale multiply.
    assign sq     = {32'd0, y_reg} * {32'd0, y_reg};
    assign sq_sh  = sq[63:30];
    assign scaled = {5'd0, exp_reg, frac_reg} * {29'd0, fpcs_pkg::CENTS_SCALE} + 45'h800000;

    always_comb begin
        state_next = state_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        y_next     = y_reg;
        frac_next  = frac_reg;
        cents_next = cents_reg;
        case (state_reg)
            LS_IDLE: begin
                if (start) begin
                    y_next     = {8'd0, (freq == '0) ? 24'd1 : freq};
                    exp_next   = 5'd23;
                    state_next = LS_NORM;
                end
            end
            // Normalize one bit a cycle until the leading one sits at bit 23.
            LS_NORM: begin
                if (y_reg[23]) begin
                    y_next     = {y_reg[24:0], 7'd0};
                    cnt_next   = 5'd0;
                    frac_next  = '0;
                    state_next = LS_SQ;
                end else begin
                    y_next   = {y_reg[30:0], 1'b0};
                    exp_next = exp_reg - 5'd1;
                end
            end
            // One fraction bit per square.
            LS_SQ: begin
                if (sq_sh[31]) begin
                    y_next    = sq_sh[32:1];
                    frac_next = {frac_reg[22:0], 1'b1};
                end else begin
                    y_next    = sq_sh[31:0];
                    frac_next = {frac_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd23) begin
                    state_next = LS_SCALE;
                end
            end
            LS_SCALE: begin
                cents_next = scaled[43:24];
                state_next = LS_DONE;
            end
            LS_DONE: begin
                state_next = LS_IDLE;
            end
            default: begin
                state_next = LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        exp_reg   <= exp_next;
        cnt_reg   <= cnt_next;
        y_reg     <= y_next;
        frac_reg  <= frac_next;
        cents_reg <= cents_next;
    end

    assign done  = (state_reg == LS_DONE);
    assign cents = cents_reg;
endmodule

[design/fpcs_checker.sv]
module fpcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpcs_pkg::ST_ZERO |-> m_tlast) else $error("error not last");
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpcs_pkg::ST_TRUNC |-> m_tlast) else $error("trunc not last");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready with pending result");
endmodule

bind fret_position_candidate_search fpcs_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);
